>>> rtl/xxh64_pkg.sv
// Shared constants, operation codes, command and status types for the XXH64 stream hasher.
package xxh64_pkg;

    // The five XXH64 primes.
    localparam logic [63:0] P1 = 64'd11400714785074694791;
    localparam logic [63:0] P2 = 64'd14029467366897019727;
    localparam logic [63:0] P3 = 64'd1609587929392839161;
    localparam logic [63:0] P4 = 64'd9650029242287828579;
    localparam logic [63:0] P5 = 64'd2870177450012600261;

    // Multiplier constant selects.
    localparam logic [2:0] K_P1 = 3'd0;
    localparam logic [2:0] K_P2 = 3'd1;
    localparam logic [2:0] K_P3 = 3'd2;
    localparam logic [2:0] K_P5 = 3'd3;

    // Operations on the working register X.
    localparam logic [3:0] X_NONE    = 4'd0;
    localparam logic [3:0] X_LD_WORD = 4'd1;
    localparam logic [3:0] X_LD_ACC  = 4'd2;
    localparam logic [3:0] X_LD_PEND = 4'd3;
    localparam logic [3:0] X_LD_WLO  = 4'd4;
    localparam logic [3:0] X_LD_BYTE = 4'd5;
    localparam logic [3:0] X_ROTADD  = 4'd6;
    localparam logic [3:0] X_ROT31   = 4'd7;
    localparam logic [3:0] X_HX_R0   = 4'd8;
    localparam logic [3:0] X_HX_R27  = 4'd9;
    localparam logic [3:0] X_HX_R23  = 4'd10;
    localparam logic [3:0] X_HX_R11  = 4'd11;
    localparam logic [3:0] X_AV33    = 4'd12;
    localparam logic [3:0] X_AV29    = 4'd13;
    localparam logic [3:0] X_MUL     = 4'd14;

    // Operations on the hash register H.
    localparam logic [2:0] H_NONE   = 3'd0;
    localparam logic [2:0] H_XOR_X  = 3'd1;
    localparam logic [2:0] H_MERGE  = 3'd2;
    localparam logic [2:0] H_SEED5  = 3'd3;
    localparam logic [2:0] H_ADDLEN = 3'd4;
    localparam logic [2:0] H_X_P4   = 3'd5;
    localparam logic [2:0] H_X_P3   = 3'd6;
    localparam logic [2:0] H_X      = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic [3:0] x_op;
        logic [2:0] h_op;
        logic [2:0] ksel;
        logic       mul_go;
        logic       acc_wr;
        logic       clr_pcnt;
        logic       out_load;
        logic [1:0] li;
        logic [2:0] bi;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       in_full;
        logic [1:0] pcnt;
        logic [3:0] tail;
        logic       last;
        logic       len_ge32;
        logic       mul_done;
    } sts_t;

    // Rotate left by n bits.
    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] n);
        rotl64 = (v << n) | (v >> (7'd64 - {1'b0, n}));
    endfunction

    // Multiplier constant for a select code.
    function automatic logic [63:0] kconst(input logic [2:0] sel);
        logic [63:0] k;
        case (sel)
            K_P1:    k = P1;
            K_P2:    k = P2;
            K_P3:    k = P3;
            default: k = P5;
        endcase
        kconst = k;
    endfunction

endpackage

>>> rtl/xxh64_mul.sv
// 64 by 64 bit low-half multiplier built on one 32 by 32 bit multiplier, summing three partial products.
module xxh64_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] k,
    output logic        done,
    output logic [63:0] prod
);

    logic [1:0]  phase_reg, phase_next;
    logic [63:0] sum_reg, sum_next;
    logic [31:0] ma, mb;
    logic [63:0] pp;

    // Operand selection per partial product.
    always_comb
    begin
        case (phase_reg)
            2'd0:    begin ma = a[31:0];  mb = k[31:0];  end
            2'd1:    begin ma = a[31:0];  mb = k[63:32]; end
            default: begin ma = a[63:32]; mb = k[31:0];  end
        endcase
        pp = {32'b0, ma} * {32'b0, mb};
    end

    // Accumulate the partial products.
    // The phase only advances while go is high, so the last phase alone marks the finish.
    always_comb
    begin
        done       = (phase_reg == 2'd2);
        sum_next   = sum_reg;
        phase_next = 2'd0;
        prod       = sum_reg + {pp[31:0], 32'b0};
        if (go)
        begin
            if (phase_reg == 2'd0)
                sum_next = pp;
            else
                sum_next = sum_reg + {pp[31:0], 32'b0};
            phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 2'd0;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

endmodule

>>> rtl/xxh64_datapath.sv
// Datapath of the XXH64 hasher: lanes, pending words, length, working and hash registers.
module xxh64_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [63:0]        cfg_wr_data,
    input  logic [63:0]        data_word,
    input  logic [3:0]         byte_count,
    input  logic               last,
    input  xxh64_pkg::cmd_t    cmd,
    output xxh64_pkg::sts_t    sts,
    output logic [63:0]        hash_value
);

    logic [63:0] seed_reg;
    logic [63:0] acc_reg [4];
    logic [63:0] pend_reg [3];
    logic [1:0]  pcnt_reg;
    logic [63:0] mlen_reg;
    logic [63:0] w_reg;
    logic [3:0]  tail_reg;
    logic        last_reg;
    logic [63:0] x_reg, x_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] hash_reg;
    logic [63:0] pend_sel;
    logic [63:0] acc_sel;
    logic [63:0] mul_prod;
    logic        mul_done;
    logic        in_full;
    logic [63:0] hx;

    // Multiplier shared by every multiply step.
    xxh64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.mul_go),
        .a     (x_reg),
        .k     (xxh64_pkg::kconst(cmd.ksel)),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Lane and pending word selection.
    always_comb
    begin
        case (cmd.li)
            2'd0:    pend_sel = pend_reg[0];
            2'd1:    pend_sel = pend_reg[1];
            default: pend_sel = pend_reg[2];
        endcase
        acc_sel = acc_reg[cmd.li];
        hx      = h_reg ^ x_reg;
        in_full = !last || (byte_count >= 4'd8);
    end

    // Working register operations.
    always_comb
    begin
        unique case (cmd.x_op)
            xxh64_pkg::X_NONE:    x_next = x_reg;
            xxh64_pkg::X_LD_WORD: x_next = (cmd.li == 2'd3) ? w_reg : pend_sel;
            xxh64_pkg::X_LD_ACC:  x_next = acc_sel;
            xxh64_pkg::X_LD_PEND: x_next = pend_sel;
            xxh64_pkg::X_LD_WLO:  x_next = {32'b0, w_reg[31:0]};
            xxh64_pkg::X_LD_BYTE: x_next = {56'b0, w_reg[8 * cmd.bi +: 8]};
            xxh64_pkg::X_ROTADD:  x_next = xxh64_pkg::rotl64(acc_sel + x_reg, 6'd31);
            xxh64_pkg::X_ROT31:   x_next = xxh64_pkg::rotl64(x_reg, 6'd31);
            xxh64_pkg::X_HX_R0:   x_next = hx;
            xxh64_pkg::X_HX_R27:  x_next = xxh64_pkg::rotl64(hx, 6'd27);
            xxh64_pkg::X_HX_R23:  x_next = xxh64_pkg::rotl64(hx, 6'd23);
            xxh64_pkg::X_HX_R11:  x_next = xxh64_pkg::rotl64(hx, 6'd11);
            xxh64_pkg::X_AV33:    x_next = h_reg ^ (h_reg >> 33);
            xxh64_pkg::X_AV29:    x_next = x_reg ^ (x_reg >> 29);
            xxh64_pkg::X_MUL:     x_next = mul_prod;
            default:              x_next = x_reg;
        endcase
    end

    // Hash register operations.
    always_comb
    begin
        unique case (cmd.h_op)
            xxh64_pkg::H_NONE:   h_next = h_reg;
            xxh64_pkg::H_XOR_X:  h_next = hx;
            xxh64_pkg::H_MERGE:  h_next = xxh64_pkg::rotl64(acc_reg[0], 6'd1)
                                        + xxh64_pkg::rotl64(acc_reg[1], 6'd7)
                                        + xxh64_pkg::rotl64(acc_reg[2], 6'd12)
                                        + xxh64_pkg::rotl64(acc_reg[3], 6'd18);
            xxh64_pkg::H_SEED5:  h_next = seed_reg + xxh64_pkg::P5;
            xxh64_pkg::H_ADDLEN: h_next = h_reg + mlen_reg;
            xxh64_pkg::H_X_P4:   h_next = x_reg + xxh64_pkg::P4;
            xxh64_pkg::H_X_P3:   h_next = x_reg + xxh64_pkg::P3;
            xxh64_pkg::H_X:      h_next = x_reg;
            default:             h_next = h_reg;
        endcase
    end

    // Stream state: seed, lanes, pending count, message length, last flag and tail count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= 64'd0;
            acc_reg[0] <= xxh64_pkg::P1 + xxh64_pkg::P2;
            acc_reg[1] <= xxh64_pkg::P2;
            acc_reg[2] <= 64'd0;
            acc_reg[3] <= 64'd0 - xxh64_pkg::P1;
            pcnt_reg   <= 2'd0;
            mlen_reg   <= 64'd0;
            last_reg   <= 1'b0;
            tail_reg   <= 4'd0;
        end
        else if (cfg_wr_en)
        begin
            seed_reg   <= cfg_wr_data;
            acc_reg[0] <= cfg_wr_data + xxh64_pkg::P1 + xxh64_pkg::P2;
            acc_reg[1] <= cfg_wr_data + xxh64_pkg::P2;
            acc_reg[2] <= cfg_wr_data;
            acc_reg[3] <= cfg_wr_data - xxh64_pkg::P1;
            pcnt_reg   <= 2'd0;
            mlen_reg   <= 64'd0;
        end
        else if (cmd.out_load)
        begin
            acc_reg[0] <= seed_reg + xxh64_pkg::P1 + xxh64_pkg::P2;
            acc_reg[1] <= seed_reg + xxh64_pkg::P2;
            acc_reg[2] <= seed_reg;
            acc_reg[3] <= seed_reg - xxh64_pkg::P1;
            pcnt_reg   <= 2'd0;
            mlen_reg   <= 64'd0;
        end
        else if (cmd.accept)
        begin
            last_reg <= last;
            if (in_full)
            begin
                mlen_reg <= mlen_reg + 64'd8;
                tail_reg <= 4'd0;
                if (pcnt_reg != 2'd3)
                    pcnt_reg <= pcnt_reg + 2'd1;
            end
            else
            begin
                mlen_reg <= mlen_reg + {60'b0, byte_count};
                tail_reg <= byte_count;
            end
        end
        else
        begin
            if (cmd.acc_wr)
                acc_reg[cmd.li] <= x_reg;
            if (cmd.clr_pcnt)
                pcnt_reg <= 2'd0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        h_reg <= h_next;
        if (cmd.accept)
        begin
            w_reg <= data_word;
            if (in_full && pcnt_reg != 2'd3)
                pend_reg[pcnt_reg] <= data_word;
        end
        if (cmd.out_load)
            hash_reg <= x_reg ^ (x_reg >> 32);
    end

    // Status to the controller.
    always_comb
    begin
        sts.in_full  = in_full;
        sts.pcnt     = pcnt_reg;
        sts.tail     = tail_reg;
        sts.last     = last_reg;
        sts.len_ge32 = |mlen_reg[63:5];
        sts.mul_done = mul_done;
    end

    assign hash_value = hash_reg;

endmodule

>>> rtl/xxh64_ctrl.sv
// Step sequencer that drives the XXH64 datapath one operation at a time.
module xxh64_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  xxh64_pkg::sts_t sts,
    output xxh64_pkg::cmd_t cmd
);

    localparam logic [5:0] ST_IDLE   = 6'd0;
    localparam logic [5:0] ST_RD_LD  = 6'd1;
    localparam logic [5:0] ST_RD_M2  = 6'd2;
    localparam logic [5:0] ST_RD_ROT = 6'd3;
    localparam logic [5:0] ST_RD_M1  = 6'd4;
    localparam logic [5:0] ST_RD_WR  = 6'd5;
    localparam logic [5:0] ST_DECIDE = 6'd6;
    localparam logic [5:0] ST_MG_LD  = 6'd7;
    localparam logic [5:0] ST_MG_M2  = 6'd8;
    localparam logic [5:0] ST_MG_ROT = 6'd9;
    localparam logic [5:0] ST_MG_M1  = 6'd10;
    localparam logic [5:0] ST_MG_XOR = 6'd11;
    localparam logic [5:0] ST_MG_MP  = 6'd12;
    localparam logic [5:0] ST_MG_ADD = 6'd13;
    localparam logic [5:0] ST_LEN    = 6'd14;
    localparam logic [5:0] ST_PD_LD  = 6'd15;
    localparam logic [5:0] ST_PD_M2  = 6'd16;
    localparam logic [5:0] ST_PD_ROT = 6'd17;
    localparam logic [5:0] ST_PD_M1  = 6'd18;
    localparam logic [5:0] ST_PD_XOR = 6'd19;
    localparam logic [5:0] ST_PD_MP  = 6'd20;
    localparam logic [5:0] ST_PD_ADD = 6'd21;
    localparam logic [5:0] ST_T4_CHK = 6'd22;
    localparam logic [5:0] ST_T4_M1  = 6'd23;
    localparam logic [5:0] ST_T4_XOR = 6'd24;
    localparam logic [5:0] ST_T4_M2  = 6'd25;
    localparam logic [5:0] ST_T4_ADD = 6'd26;
    localparam logic [5:0] ST_B_CHK  = 6'd27;
    localparam logic [5:0] ST_B_M5   = 6'd28;
    localparam logic [5:0] ST_B_XOR  = 6'd29;
    localparam logic [5:0] ST_B_M1   = 6'd30;
    localparam logic [5:0] ST_B_SET  = 6'd31;
    localparam logic [5:0] ST_AV_LD  = 6'd32;
    localparam logic [5:0] ST_AV_M2  = 6'd33;
    localparam logic [5:0] ST_AV_X29 = 6'd34;
    localparam logic [5:0] ST_AV_M3  = 6'd35;
    localparam logic [5:0] ST_FIN    = 6'd36;

    logic [5:0] state_reg, state_next;
    logic [1:0] li_reg, li_next;
    logic [2:0] bi_reg, bi_next;
    logic       ovalid_reg, ovalid_next;

    // Multiply step: hold until the multiplier finishes, then take its product.
    function automatic void mul_step(input logic [2:0] k, input logic [5:0] nxt,
                                     input logic done, inout xxh64_pkg::cmd_t c,
                                     inout logic [5:0] st);
        c.mul_go = 1'b1;
        c.ksel   = k;
        if (done)
        begin
            c.x_op = xxh64_pkg::X_MUL;
            st     = nxt;
        end
    endfunction

    // Step decoding and sequencing.
    always_comb
    begin
        cmd          = '0;
        cmd.x_op     = xxh64_pkg::X_NONE;
        cmd.h_op     = xxh64_pkg::H_NONE;
        cmd.ksel     = xxh64_pkg::K_P1;
        state_next   = state_reg;
        li_next      = li_reg;
        bi_next      = bi_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    li_next    = 2'd0;
                    state_next = (sts.in_full && sts.pcnt == 2'd3) ? ST_RD_LD : ST_DECIDE;
                end
            end
            ST_RD_LD:
            begin
                cmd.x_op   = xxh64_pkg::X_LD_WORD;
                state_next = ST_RD_M2;
            end
            ST_RD_M2:  mul_step(xxh64_pkg::K_P2, ST_RD_ROT, sts.mul_done, cmd, state_next);
            ST_RD_ROT:
            begin
                cmd.x_op   = xxh64_pkg::X_ROTADD;
                state_next = ST_RD_M1;
            end
            ST_RD_M1:  mul_step(xxh64_pkg::K_P1, ST_RD_WR, sts.mul_done, cmd, state_next);
            ST_RD_WR:
            begin
                cmd.acc_wr = 1'b1;
                if (li_reg == 2'd3)
                begin
                    cmd.clr_pcnt = 1'b1;
                    li_next      = 2'd0;
                    state_next   = ST_DECIDE;
                end
                else
                begin
                    li_next    = li_reg + 2'd1;
                    state_next = ST_RD_LD;
                end
            end
            ST_DECIDE:
            begin
                li_next = 2'd0;
                if (!sts.last)
                    state_next = ST_IDLE;
                else if (sts.len_ge32)
                begin
                    cmd.h_op   = xxh64_pkg::H_MERGE;
                    state_next = ST_MG_LD;
                end
                else
                begin
                    cmd.h_op   = xxh64_pkg::H_SEED5;
                    state_next = ST_LEN;
                end
            end
            ST_MG_LD:
            begin
                cmd.x_op   = xxh64_pkg::X_LD_ACC;
                state_next = ST_MG_M2;
            end
            ST_MG_M2:  mul_step(xxh64_pkg::K_P2, ST_MG_ROT, sts.mul_done, cmd, state_next);
            ST_MG_ROT:
            begin
                cmd.x_op   = xxh64_pkg::X_ROT31;
                state_next = ST_MG_M1;
            end
            ST_MG_M1:  mul_step(xxh64_pkg::K_P1, ST_MG_XOR, sts.mul_done, cmd, state_next);
            ST_MG_XOR:
            begin
                cmd.h_op   = xxh64_pkg::H_XOR_X;
                cmd.x_op   = xxh64_pkg::X_HX_R0;
                state_next = ST_MG_MP;
            end
            ST_MG_MP:  mul_step(xxh64_pkg::K_P1, ST_MG_ADD, sts.mul_done, cmd, state_next);
            ST_MG_ADD:
            begin
                cmd.h_op = xxh64_pkg::H_X_P4;
                if (li_reg == 2'd3)
                    state_next = ST_LEN;
                else
                begin
                    li_next    = li_reg + 2'd1;
                    state_next = ST_MG_LD;
                end
            end
            ST_LEN:
            begin
                cmd.h_op   = xxh64_pkg::H_ADDLEN;
                li_next    = 2'd0;
                state_next = (sts.pcnt == 2'd0) ? ST_T4_CHK : ST_PD_LD;
            end
            ST_PD_LD:
            begin
                cmd.x_op   = xxh64_pkg::X_LD_PEND;
                state_next = ST_PD_M2;
            end
            ST_PD_M2:  mul_step(xxh64_pkg::K_P2, ST_PD_ROT, sts.mul_done, cmd, state_next);
            ST_PD_ROT:
            begin
                cmd.x_op   = xxh64_pkg::X_ROT31;
                state_next = ST_PD_M1;
            end
            ST_PD_M1:  mul_step(xxh64_pkg::K_P1, ST_PD_XOR, sts.mul_done, cmd, state_next);
            ST_PD_XOR:
            begin
                cmd.h_op   = xxh64_pkg::H_XOR_X;
                cmd.x_op   = xxh64_pkg::X_HX_R27;
                state_next = ST_PD_MP;
            end
            ST_PD_MP:  mul_step(xxh64_pkg::K_P1, ST_PD_ADD, sts.mul_done, cmd, state_next);
            ST_PD_ADD:
            begin
                cmd.h_op = xxh64_pkg::H_X_P4;
                if (({1'b0, li_reg} + 3'd1) < {1'b0, sts.pcnt})
                begin
                    li_next    = li_reg + 2'd1;
                    state_next = ST_PD_LD;
                end
                else
                    state_next = ST_T4_CHK;
            end
            ST_T4_CHK:
            begin
                if (sts.tail >= 4'd4)
                begin
                    cmd.x_op   = xxh64_pkg::X_LD_WLO;
                    state_next = ST_T4_M1;
                end
                else
                begin
                    bi_next    = 3'd0;
                    state_next = ST_B_CHK;
                end
            end
            ST_T4_M1:  mul_step(xxh64_pkg::K_P1, ST_T4_XOR, sts.mul_done, cmd, state_next);
            ST_T4_XOR:
            begin
                cmd.h_op   = xxh64_pkg::H_XOR_X;
                cmd.x_op   = xxh64_pkg::X_HX_R23;
                state_next = ST_T4_M2;
            end
            ST_T4_M2:  mul_step(xxh64_pkg::K_P2, ST_T4_ADD, sts.mul_done, cmd, state_next);
            ST_T4_ADD:
            begin
                cmd.h_op   = xxh64_pkg::H_X_P3;
                bi_next    = 3'd4;
                state_next = ST_B_CHK;
            end
            ST_B_CHK:
            begin
                if ({1'b0, bi_reg} < sts.tail)
                begin
                    cmd.x_op   = xxh64_pkg::X_LD_BYTE;
                    state_next = ST_B_M5;
                end
                else
                    state_next = ST_AV_LD;
            end
            ST_B_M5:   mul_step(xxh64_pkg::K_P5, ST_B_XOR, sts.mul_done, cmd, state_next);
            ST_B_XOR:
            begin
                cmd.h_op   = xxh64_pkg::H_XOR_X;
                cmd.x_op   = xxh64_pkg::X_HX_R11;
                state_next = ST_B_M1;
            end
            ST_B_M1:   mul_step(xxh64_pkg::K_P1, ST_B_SET, sts.mul_done, cmd, state_next);
            ST_B_SET:
            begin
                cmd.h_op   = xxh64_pkg::H_X;
                bi_next    = bi_reg + 3'd1;
                state_next = ST_B_CHK;
            end
            ST_AV_LD:
            begin
                cmd.x_op   = xxh64_pkg::X_AV33;
                state_next = ST_AV_M2;
            end
            ST_AV_M2:  mul_step(xxh64_pkg::K_P2, ST_AV_X29, sts.mul_done, cmd, state_next);
            ST_AV_X29:
            begin
                cmd.x_op   = xxh64_pkg::X_AV29;
                state_next = ST_AV_M3;
            end
            ST_AV_M3:  mul_step(xxh64_pkg::K_P3, ST_FIN, sts.mul_done, cmd, state_next);
            ST_FIN:
            begin
                // Wait here only while an earlier hash is still waiting to be taken.
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
        cmd.li = li_reg;
        cmd.bi = bi_reg;
    end

    // Output valid flag.
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        if (cmd.out_load)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            li_reg     <= 2'd0;
            bi_reg     <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            li_reg     <= li_next;
            bi_reg     <= bi_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;

endmodule

>>> rtl/xxh64_stream_hasher.sv
// Top level of the streaming XXH64 hasher: controller, datapath and checks.
// A full word that does not close a lane group is only stored; the fourth word of a group
// runs four lane rounds, each two passes of the shared 32x32 multiplier.
// A last word adds a finish made of the multiplier passes for merge, pending words,
// tail bytes and avalanche; the hash then sits in an output register.
// Reset (rst_n low, asynchronous) clears the seed to zero, loads the lanes for seed zero
// and empties the stream; a seed write restarts the stream the same way.
module xxhash64_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value
);

    xxh64_pkg::cmd_t cmd;
    xxh64_pkg::sts_t sts;

    // Step sequencer.
    xxh64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic and stream state.
    xxh64_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .last        (last),
        .cmd         (cmd),
        .sts         (sts),
        .hash_value  (hash_value)
    );

    // A request without the last mark never produces a hash in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !last) |=> !$rose(out_valid))
        else $error("hash raised after a non-final request");

    // A new hash is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("waiting hash overwritten");

    // The multiplier never runs while a request is being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.mul_go)
        else $error("multiplier active during request accept");

endmodule
